/* sv/pmrc_pkg.sv */
package pmrc_pkg;

  // command codes carried in s_axis_tuser
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_SET    = 3'd1;
  localparam logic [2:0] FUNC_RAMP   = 3'd2;
  localparam logic [2:0] FUNC_TIMED  = 3'd3;
  localparam logic [2:0] FUNC_FWD    = 3'd4;
  localparam logic [2:0] FUNC_REV    = 3'd5;
  localparam logic [2:0] FUNC_TOGGLE = 3'd6;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned SV_W       = 10;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 16;

  localparam logic [SPEED_W-1:0] FULL_SPEED = 8'd255;

  // floor(x / 100) = (x * 41944) >> 22, exact for x < 43690; above that it
  // is at most one high, and such steps are out of range either way
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int unsigned RECIP_SH  = 22;

  typedef struct packed {
    logic load;
    logic tick_inc;
    logic div_start;
    logic mul;
    logic scale;
    logic apply;
    logic emit;
  } pmrc_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic need_div;
    logic div_busy;
  } pmrc_sts_t;

endpackage

/* sv/pwm_motor_ramp_controller.sv */
// Set speed, ramp, timed-on, direction and unused codes go from accept
// straight to apply and emit; a tick first updates the timer, and a tick that
// computes a ramp step also runs the serial divider for the percent, then
// multiply and divide-by-100 stages. One request at a time: a new one is
// taken the cycle after the result is loaded into the output register.
// Reset (rst_ni low, async): speed 0, forward, no ramp or timed-on, timer 0.
module pwm_motor_ramp_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] func
  input  logic [pmrc_pkg::FUNC_W-1:0]    s_axis_tuser,
  // [9:0] speed_value (signed), [10] stop_all, [42:11] duration_ms, [47:43] zero
  input  logic [pmrc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] speed, [8] is_forward, [9] ramping, [10] timed_on_active,
  // [11] target_reached, [12] entered_forward, [13] entered_reverse, [15:14] zero
  output logic [pmrc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // bidirectional register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);
  import pmrc_pkg::*;

  pmrc_cmd_t cmd;
  pmrc_sts_t sts;

  // register writes are taken at any time; the user must write only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  // sequencer: accept, tick timer update, ramp step pipeline, commit, emit
  pmrc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // motor state, timer, percent divider and the output register
  pmrc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .func_i     (s_axis_tuser),
    .item_i     (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .result_o   (m_axis_tdata)
  );

endmodule

/* sv/pmrc_pct_div.sv */
module pmrc_pct_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pmrc_pkg::DUR_W-1:0] elapsed_i,
  input  logic [pmrc_pkg::DUR_W-1:0] limit_i,
  output logic                      busy_o,
  output logic [pmrc_pkg::PCT_W-1:0] pct_o
);
  import pmrc_pkg::*;

  localparam int unsigned REM_W = DUR_W + PCT_W;

  logic [REM_W-1:0] rem_q, rem_d, num, den_sh;
  logic [PCT_W-1:0] quo_q, quo_d;
  logic [2:0]       k_q, k_d;
  logic             busy_q, busy_d;

  // elapsed * 100 = e*64 + e*32 + e*4
  assign num = {1'b0, elapsed_i, 6'b0} + {2'b0, elapsed_i, 5'b0} + {5'b0, elapsed_i, 2'b0};
  assign den_sh = {{PCT_W{1'b0}}, limit_i} << k_q;

  // restoring division, one quotient bit per cycle, msb first
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    k_d    = k_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num;
      quo_d  = '0;
      k_d    = 3'(PCT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= den_sh) begin
        rem_d      = rem_q - den_sh;
        quo_d[k_q] = 1'b1;
      end
      if (k_q == 3'd0) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign pct_o  = quo_q;

endmodule

/* sv/pmrc_datapath.sv */
module pmrc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pmrc_pkg::pmrc_cmd_t           cmd_i,
  output pmrc_pkg::pmrc_sts_t           sts_o,
  input  logic [pmrc_pkg::FUNC_W-1:0]    func_i,
  input  logic [pmrc_pkg::S_TDATA_W-1:0] item_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_data_i,
  output logic [pmrc_pkg::M_TDATA_W-1:0] result_o
);
  import pmrc_pkg::*;

  // latched request
  logic [FUNC_W-1:0] func_q;
  logic [SV_W-1:0]   sv_q;
  logic              stop_q;
  logic [DUR_W-1:0]  dur_q;

  // architectural state
  logic               bidir_q;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic               dir_q, dir_d;
  logic               timed_q, timed_d;
  logic               ramp_q, ramp_d;
  logic               stopped_q, stopped_d;
  logic               hit_q, hit_d;
  logic               fwd_q, fwd_d;
  logic               rev_q, rev_d;
  logic [SPEED_W-1:0] start_q, start_d;
  logic [SV_W-1:0]    target_q, target_d;
  logic [DUR_W-1:0]   limit_q, limit_d;
  logic [DUR_W-1:0]   elapsed_q, elapsed_d;

  // ramp step pipeline
  logic [PCT_W-1:0]     pct;
  logic                 div_busy;
  logic [SV_W:0]        diff;
  logic signed [18:0]   prod_d, prod_q;
  logic [16:0]          mag;
  logic [31:0]          recip_d, recip_q;
  logic                 neg_q;
  logic [9:0]           quo;
  logic [SV_W:0]        fdiv;
  logic [11:0]          step;
  logic                 step_ok, target_ok, sv_ok, active, cond;
  logic                 tr, ef, er;
  logic [M_TDATA_W-1:0] result_q;

  pmrc_pct_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .elapsed_i (elapsed_q),
    .limit_i   (limit_q),
    .busy_o    (div_busy),
    .pct_o     (pct)
  );

  assign active = elapsed_q < limit_q;

  assign diff   = {target_q[SV_W-1], target_q} - {3'b0, start_q};
  assign prod_d = $signed({1'b0, pct}) * $signed(diff);
  // floor division by 100 of a signed value via magnitude (up to 99*767+99)
  assign mag     = prod_q[18] ? 17'(19'd99 - prod_q) : 17'(prod_q);
  assign recip_d = 32'(mag) * 32'(RECIP_100);
  assign quo     = recip_q[31:RECIP_SH];
  assign fdiv    = neg_q ? (11'd0 - {1'b0, quo}) : {1'b0, quo};
  assign step    = {4'b0, start_q} + {fdiv[SV_W], fdiv};

  assign step_ok   = step[11:8] == 4'd0;
  assign target_ok = target_q[SV_W-1:8] == 2'd0;
  assign sv_ok     = sv_q[SV_W-1:8] == 2'd0;
  assign cond      = !active && !timed_q && !ramp_q && !stopped_q;

  always_comb begin
    speed_d   = speed_q;
    dir_d     = dir_q;
    timed_d   = timed_q;
    ramp_d    = ramp_q;
    stopped_d = stopped_q;
    hit_d     = hit_q;
    fwd_d     = fwd_q;
    rev_d     = rev_q;
    start_d   = start_q;
    target_d  = target_q;
    limit_d   = limit_q;
    elapsed_d = elapsed_q;
    tr        = 1'b0;
    ef        = 1'b0;
    er        = 1'b0;

    if (cmd_i.tick_inc && (elapsed_q != '1)) begin
      elapsed_d = elapsed_q + 1'b1;
    end

    if (cmd_i.apply) begin
      unique case (func_q)
        FUNC_TICK: begin
          if (timed_q) begin
            if (active) begin
              speed_d   = FULL_SPEED;
              stopped_d = 1'b0;
            end else begin
              speed_d   = '0;
              timed_d   = 1'b0;
              ramp_d    = 1'b0;
              stopped_d = 1'b1;
            end
          end else if (ramp_q) begin
            if (active) begin
              if (step_ok) begin
                speed_d   = step[SPEED_W-1:0];
                stopped_d = 1'b0;
              end
            end else begin
              if (target_ok) begin
                speed_d   = target_q[SPEED_W-1:0];
                stopped_d = 1'b0;
              end
              ramp_d = 1'b0;
            end
          end
        end
        FUNC_SET: begin
          if (sv_ok) begin
            speed_d = sv_q[SPEED_W-1:0];
            if (stop_q) begin
              timed_d   = 1'b0;
              ramp_d    = 1'b0;
              stopped_d = 1'b1;
            end else begin
              stopped_d = 1'b0;
            end
          end
        end
        FUNC_RAMP: begin
          timed_d   = 1'b0;
          stopped_d = 1'b1;
          start_d   = speed_q;
          target_d  = sv_q;
          if (sv_q != {2'b0, speed_q}) begin
            limit_d   = dur_q;
            elapsed_d = '0;
            ramp_d    = 1'b1;
          end else begin
            ramp_d = 1'b0;
          end
        end
        FUNC_TIMED: begin
          timed_d   = 1'b1;
          ramp_d    = 1'b0;
          stopped_d = 1'b1;
          limit_d   = dur_q;
          elapsed_d = '0;
        end
        FUNC_FWD, FUNC_REV, FUNC_TOGGLE: begin
          if (bidir_q) begin
            if (func_q == FUNC_FWD) begin
              dir_d = 1'b1;
            end else if (func_q == FUNC_REV) begin
              dir_d = 1'b0;
            end else begin
              dir_d = ~dir_q;
            end
            speed_d   = '0;
            timed_d   = 1'b0;
            ramp_d    = 1'b0;
            stopped_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // event pulses from the post-command state
    if (cmd_i.emit) begin
      tr    = cond && !hit_q;
      hit_d = cond;
      if (bidir_q) begin
        if (dir_q) begin
          ef    = !fwd_q;
          fwd_d = 1'b1;
          rev_d = 1'b0;
        end else begin
          er    = !rev_q;
          rev_d = 1'b1;
          fwd_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidir_q   <= 1'b0;
      speed_q   <= '0;
      dir_q     <= 1'b1;
      timed_q   <= 1'b0;
      ramp_q    <= 1'b0;
      stopped_q <= 1'b0;
      hit_q     <= 1'b0;
      fwd_q     <= 1'b0;
      rev_q     <= 1'b0;
      start_q   <= '0;
      target_q  <= '0;
      limit_q   <= '0;
      elapsed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        bidir_q <= cfg_data_i;
      end
      speed_q   <= speed_d;
      dir_q     <= dir_d;
      timed_q   <= timed_d;
      ramp_q    <= ramp_d;
      stopped_q <= stopped_d;
      hit_q     <= hit_d;
      fwd_q     <= fwd_d;
      rev_q     <= rev_d;
      start_q   <= start_d;
      target_q  <= target_d;
      limit_q   <= limit_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      sv_q   <= item_i[SV_W-1:0];
      stop_q <= item_i[SV_W];
      dur_q  <= item_i[SV_W+DUR_W:SV_W+1];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.scale) begin
      recip_q <= recip_d;
      neg_q   <= prod_q[18];
    end
    if (cmd_i.emit) begin
      result_q <= {2'b0, er, ef, tr, timed_q, ramp_q, dir_q, speed_q};
    end
  end

  assign sts_o.is_tick  = func_i == FUNC_TICK;
  assign sts_o.need_div = ramp_q && active;
  assign sts_o.div_busy = div_busy;
  assign result_o       = result_q;

`ifndef SYNTHESIS
  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(timed_q && ramp_q))
    else $error("timed-on and ramp active together");
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(div_busy) |-> (pct < 7'd100))
    else $error("ramp percent out of range");
  a_hit_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && tr) |=> hit_q)
    else $error("target event without latch");
`endif

endmodule

/* sv/pmrc_ctrl.sv */
module pmrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  pmrc_pkg::pmrc_sts_t sts_i,
  output pmrc_pkg::pmrc_cmd_t cmd_o
);
  import pmrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_SCALE,
    ST_APPLY,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign s_axis_tready = state_q == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    state_d         = state_q;
    out_valid_d     = out_valid_q && !m_axis_tready;
    cmd_o.load      = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.is_tick ? ST_INC : ST_APPLY;
        end
      end
      ST_INC: begin
        cmd_o.tick_inc = 1'b1;
        state_d        = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // wait for a free output register
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("request accepted but controller stayed idle");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside done state");
  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> sts_i.div_busy)
    else $error("divider did not start");
`endif

endmodule

/* tb/tb_pwm_motor_ramp_controller.sv */
`timescale 1ns / 100ps

module tb_pwm_motor_ramp_controller;
  import pmrc_pkg::*;

  // unused command code; the block must still report status for it
  localparam logic [2:0] FUNC_NONE = 3'd7;

  localparam int unsigned LONG_HOLD      = 200;   // receiver hold-off, cycles
  localparam int unsigned DRAIN_SLACK    = 20;    // settle cycles after the last status word
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transfer

  // one status word as the block reports it
  typedef struct packed {
    logic [7:0] duty;
    logic       fwd;
    logic       ramp_on;
    logic       full_on;
    logic       reached;
    logic       ent_fwd;
    logic       ent_rev;
  } motor_status_t;

  // ---------------------------------------------------------------------
  // clock, reset, block inputs (all known from time 0)
  // ---------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [FUNC_W-1:0]    s_axis_tuser  = FUNC_TICK;   // [2:0] func
  // [9:0] speed_value, [10] stop_all, [42:11] duration_ms, [47:43] zero
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [7:0] speed, [8] is_forward, [9] ramping, [10] timed_on_active,
  // [11] target_reached, [12] entered_forward, [13] entered_reverse
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i    = 1'b0;

  always #5 clk_i = ~clk_i;

  pwm_motor_ramp_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // motor model state: duty, direction, activity, event latches, timer
  // ---------------------------------------------------------------------
  bit          bidir_cfg;
  bit   [7:0]  duty;
  bit          dir_fwd = 1'b1;
  bit          timed_on, ramping, halted;
  bit          reach_latch, fwd_latch, rev_latch;
  bit   [7:0]  ramp_from;
  int          ramp_to;
  bit   [31:0] tmr_limit, tmr_count;

  motor_status_t pending_status[$];   // status words still to arrive

  // run control and bookkeeping
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned n_errors, n_sent, n_ticks, n_ramps, n_timed, n_cfg;
  int unsigned n_checked, n_reached, n_dir_events;
  int unsigned quiet_cycles;

  // full stop: drop ramp and timed-on, mute the target event
  function automatic void halt_motion();
    timed_on = 1'b0;
    ramping  = 1'b0;
    halted   = 1'b1;
  endfunction

  // out-of-range speeds are dropped entirely, stop flag included
  function automatic void drive_speed(input int v, input bit stop);
    if (v < 0 || v > 255) return;
    if (stop) halt_motion();
    else      halted = 1'b0;
    duty = v[7:0];
  endfunction

  function automatic void steer(input bit fwd);
    if (!bidir_cfg) return;
    dir_fwd = fwd;
    drive_speed(0, 1'b1);
  endfunction

  function automatic void motor_tick();
    longint unsigned num;
    int              pct, step;
    if (tmr_count != 32'hFFFF_FFFF) tmr_count++;
    if (timed_on) begin
      if (tmr_count < tmr_limit) begin
        drive_speed(255, 1'b0);
      end else begin
        drive_speed(0, 1'b1);
        timed_on = 1'b0;
      end
    end
    if (ramping) begin
      if (tmr_count < tmr_limit) begin
        // percent of elapsed time, then floor of pct*diff/100 (toward -inf)
        num  = tmr_count;
        num  = (num * 100) / tmr_limit;
        pct  = int'(num);
        step = pct * (ramp_to - int'(ramp_from));
        step = (step >= 0) ? step / 100 : -((-step + 99) / 100);
        drive_speed(int'(ramp_from) + step, 1'b0);
      end else begin
        drive_speed(ramp_to, 1'b0);
        ramping = 1'b0;
      end
    end
  endfunction

  // apply one command to the model and return the status it produces
  function automatic motor_status_t next_motor_status(input logic [2:0] func,
                                                      input logic [9:0] spd_raw,
                                                      input logic stop,
                                                      input logic [31:0] dur);
    motor_status_t st;
    int            spd;
    spd = $signed(spd_raw);
    st  = '0;
    case (func)
      FUNC_TICK:   motor_tick();
      FUNC_SET:    drive_speed(spd, stop);
      FUNC_RAMP: begin
        halt_motion();
        ramp_from = duty;
        ramp_to   = spd;
        // no ramp at all when already at the target
        if (ramp_to != int'(ramp_from)) begin
          tmr_limit = dur;
          tmr_count = '0;
          ramping   = 1'b1;
        end
      end
      FUNC_TIMED: begin
        halt_motion();
        timed_on  = 1'b1;
        tmr_limit = dur;
        tmr_count = '0;
      end
      FUNC_FWD:    steer(1'b1);
      FUNC_REV:    steer(1'b0);
      FUNC_TOGGLE: steer(!dir_fwd);
      default: ;
    endcase

    // target event: one pulse while the timer is done and nothing pending
    if (!(tmr_count < tmr_limit) && !timed_on && !ramping && !halted) begin
      if (!reach_latch) begin
        reach_latch = 1'b1;
        st.reached  = 1'b1;
      end
    end else begin
      reach_latch = 1'b0;
    end

    // direction events only in bidirectional mode; latches hold otherwise
    if (bidir_cfg) begin
      if (dir_fwd) begin
        if (!fwd_latch) begin
          fwd_latch  = 1'b1;
          st.ent_fwd = 1'b1;
        end
        rev_latch = 1'b0;
      end else begin
        if (!rev_latch) begin
          rev_latch  = 1'b1;
          st.ent_rev = 1'b1;
        end
        fwd_latch = 1'b0;
      end
    end

    st.duty    = duty;
    st.fwd     = dir_fwd;
    st.ramp_on = ramping;
    st.full_on = timed_on;
    return st;
  endfunction

  // ---------------------------------------------------------------------
  // random field helpers
  // ---------------------------------------------------------------------
  function automatic bit coin();
    logic [31:0] r;
    r = $urandom();
    return r[0];
  endfunction

  // mostly legal duty values, some out of range on both sides
  function automatic logic [9:0] pick_speed();
    int v;
    if ($urandom_range(0, 4) == 0) v = int'($urandom_range(0, 767)) - 256;
    else                           v = int'($urandom_range(0, 255));
    return v[9:0];
  endfunction

  // short durations so ramps and timed-on finish; now and then a huge one
  function automatic logic [31:0] pick_duration();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0)      return $urandom();
    else if (sel < 3)  return 32'($urandom_range(13, 60));
    else               return 32'($urandom_range(0, 12));
  endfunction

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------
  // Valid stays high across back-to-back requests; it only drops when a
  // gap is drawn or the input is idled, so it never gets two updates in one step.
  task automatic send_cmd(input logic [2:0] func, input logic [9:0] spd,
                          input logic stop, input logic [31:0] dur);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'b0, dur, stop, spd};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_status.push_back(next_motor_status(func, spd, stop, dur));
    n_sent++;
    if (func == FUNC_TICK)  n_ticks++;
    if (func == FUNC_RAMP)  n_ramps++;
    if (func == FUNC_TIMED) n_timed++;
  endtask

  task automatic tick_n(input int unsigned n);
    repeat (n) send_cmd(FUNC_TICK, pick_speed(), coin(), $urandom());
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // wait for every outstanding status word, then let the pipe settle
  task automatic wait_drained();
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  // register write only with the block idle
  task automatic write_bidir(input logic val);
    idle_input();
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bidir_cfg = val;
    n_cfg++;
  endtask

  // ---------------------------------------------------------------------
  // result side: random stall per status word, plus an optional long
  // hold-off that the pressure test asks for
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = sink_idle_en ? $urandom_range(0, 15) : 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic void check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      n_errors++;
    end
  endfunction

  // compare each status word with the oldest prediction
  always @(posedge clk_i) begin : status_check
    motor_status_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_status.size() == 0) begin
        $display("%0t ns: unexpected status word, expected none, got 0x%h",
                 $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("speed",           want.duty,    m_axis_tdata[7:0]);
        check_field("is_forward",      want.fwd,     m_axis_tdata[8]);
        check_field("ramping",         want.ramp_on, m_axis_tdata[9]);
        check_field("timed_on_active", want.full_on, m_axis_tdata[10]);
        check_field("target_reached",  want.reached, m_axis_tdata[11]);
        check_field("entered_forward", want.ent_fwd, m_axis_tdata[12]);
        check_field("entered_reverse", want.ent_rev, m_axis_tdata[13]);
        n_checked++;
        if (want.reached) n_reached++;
        if (want.ent_fwd || want.ent_rev) n_dir_events++;
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  // duty extremes, stop flag, out-of-range speeds on both sides
  task automatic test_speed_limits();
    send_cmd(FUNC_TICK, 10'd0,   1'b0, 32'd0);   // expired timer -> target pulse
    send_cmd(FUNC_SET,  10'd255, 1'b0, 32'd0);
    send_cmd(FUNC_SET,  -10'sd1, 1'b1, 32'd0);   // ignored, stop too
    send_cmd(FUNC_SET,  10'd511, 1'b0, 32'd0);   // ignored
    send_cmd(FUNC_SET,  -10'sd256, 1'b1, 32'd0); // ignored
    send_cmd(FUNC_SET,  10'd0,   1'b1, 32'hFFFF_FFFF);
  endtask

  // ramp up and land, ramp to same speed, huge duration, negative target
  task automatic test_ramp_profile();
    send_cmd(FUNC_RAMP, 10'd200, 1'b0, 32'd3);
    tick_n(4);
    send_cmd(FUNC_RAMP, 10'd200, 1'b0, 32'd9);   // already there: no ramp
    send_cmd(FUNC_RAMP, 10'd100, 1'b0, 32'hFFFF_FFFF);
    tick_n(1);
    send_cmd(FUNC_RAMP, -10'sd40, 1'b1, 32'd2);  // step stays in range, landing dropped
    tick_n(3);
  endtask

  // timed full-on expiring, and one that never expires
  task automatic test_timed_on();
    send_cmd(FUNC_TIMED, 10'd7, 1'b0, 32'd2);
    tick_n(3);
    send_cmd(FUNC_TIMED, 10'd0, 1'b1, 32'hFFFF_FFFF);
    tick_n(1);
  endtask

  // direction commands ignored, then live in bidirectional mode
  task automatic test_direction();
    send_cmd(FUNC_REV,    10'd0, 1'b0, 32'd0);
    send_cmd(FUNC_TOGGLE, 10'd0, 1'b0, 32'd0);
    write_bidir(1'b1);
    send_cmd(FUNC_REV,    10'd0, 1'b0, 32'd0);
    send_cmd(FUNC_TOGGLE, 10'd0, 1'b0, 32'd0);
    send_cmd(FUNC_FWD,    10'd0, 1'b0, 32'd0);   // already forward: no pulse
    send_cmd(FUNC_NONE,   10'h3FF, 1'b1, 32'hFFFF_FFFF);
  endtask

  // half the time ramp or timed-on followed by a run of ticks; the rest is loose
  // commands and fully random noise
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned stop_at, sel;
    logic [31:0] r;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      sel = $urandom_range(0, 9);
      r   = $urandom();
      if (sel < 5) begin
        send_cmd(r[0] ? FUNC_RAMP : FUNC_TIMED, pick_speed(), r[1], pick_duration());
        repeat ($urandom_range(0, 15)) begin
          if ($urandom_range(0, 11) == 0) send_cmd(FUNC_SET, pick_speed(), coin(), $urandom());
          else                            tick_n(1);
        end
      end else if (sel == 5) begin
        send_cmd(FUNC_SET, pick_speed(), r[0], $urandom());
      end else if (sel == 6) begin
        send_cmd(r[1] ? FUNC_TOGGLE : (r[0] ? FUNC_FWD : FUNC_REV),
                 pick_speed(), r[2], $urandom());
      end else if (sel == 7) begin
        tick_n($urandom_range(1, 8));
      end else begin
        send_cmd(r[2:0], r[12:3], r[13], $urandom());
      end
    end
  endtask

  // receiver holds off while requests keep coming: input must stall
  task automatic test_output_backpressure();
    src_idle_en  = 1'b0;
    hold_off_req = 1'b1;
    send_cmd(FUNC_RAMP, 10'd250, 1'b0, 32'd20);
    tick_n(30);
    src_idle_en  = 1'b1;
  endtask

  // sender stops mid-ramp until all status words are in, then resumes
  task automatic test_source_pause();
    send_cmd(FUNC_SET,  10'd30,  1'b0, 32'd0);
    send_cmd(FUNC_RAMP, 10'd180, 1'b0, 32'd8);
    tick_n(4);
    idle_input();
    wait_drained();
    tick_n(6);
    test_random_mix(30);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_speed_limits();
    test_ramp_profile();
    test_timed_on();
    test_direction();

    // random phases with different register values and idling patterns
    test_random_mix(300);
    write_bidir(1'b0);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_mix(250);
    write_bidir(1'b1);
    src_idle_en  = 1'b1;
    test_random_mix(250);
    sink_idle_en = 1'b1;
    test_output_backpressure();
    test_source_pause();
    write_bidir(1'b0);
    src_idle_en  = 1'b0;
    test_random_mix(300);

    idle_input();
    wait_drained();
    $display("Sent %0d commands: %0d ticks, %0d ramps, %0d timed-on; %0d register writes",
             n_sent, n_ticks, n_ramps, n_timed, n_cfg);
    $display("Checked %0d status words, %0d target events, %0d direction events",
             n_checked, n_reached, n_dir_events);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
